// ===== rtl/ps2hs_pkg.sv =====
`default_nettype none

package ps2hs_pkg;

  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int TIMER_BITS_DEF  = 16;
  localparam int CMD_W           = 8;
  localparam int STATUS_W        = 2;

  localparam logic [CFG_W-1:0] INHIBIT_RESET = 16'd300;
  localparam logic [CFG_W-1:0] REQUEST_RESET = 16'd20;
  localparam logic [CFG_W-1:0] WAIT_RESET    = 16'd10000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INHIBIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT    = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ACK     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] inhibit_ticks;
    logic [CFG_W-1:0] request_ticks;
    logic [CFG_W-1:0] wait_limit;
  } cfg_t;

  typedef struct packed {
    logic                clk_pull_low;
    logic                data_drive;
    logic                data_level;
    logic                busy_res;
    logic [STATUS_W-1:0] status;
  } res_t;

  function automatic logic odd_parity(input logic [CMD_W-1:0] b);
    return ~(^b);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ps2hs_cfg.sv =====
`default_nettype none

module ps2hs_cfg
  import ps2hs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inhibit_ticks <= INHIBIT_RESET;
      cfg.request_ticks <= REQUEST_RESET;
      cfg.wait_limit    <= WAIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INHIBIT: cfg.inhibit_ticks <= cfg_wdata;
        CFG_REQUEST: cfg.request_ticks <= cfg_wdata;
        CFG_WAIT:    cfg.wait_limit    <= cfg_wdata;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ps2hs_core.sv =====
`default_nettype none

module ps2hs_core
  import ps2hs_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic             start_req,
  input  wire logic [CMD_W-1:0] command,
  input  wire logic             clk_pin,
  input  wire logic             data_pin,
  input  wire cfg_t             cfg,
  output res_t                  res
);

  localparam int LW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_INHIBIT   = 4'd1,
    PH_REQUEST   = 4'd2,
    PH_START     = 4'd3,
    PH_BIT_HIGH  = 4'd4,
    PH_BIT_LOW   = 4'd5,
    PH_ACK_DLOW  = 4'd6,
    PH_ACK_CLOW  = 4'd7,
    PH_ACK_DHIGH = 4'd8,
    PH_ACK_CHIGH = 4'd9
  } phase_t;

  phase_t                phase, phase_next;
  logic [CMD_W-1:0]      shift_byte, shift_byte_next;
  logic                  parity_bit, parity_bit_next;
  logic [3:0]            bit_count, bit_count_next;
  logic [TIMER_BITS-1:0] tick_timer, tick_timer_next;
  logic                  data_out_reg, data_out_reg_next;

  logic [TIMER_BITS-1:0] timer_sat;
  logic [TIMER_BITS-1:0] lim_inhibit, lim_request, lim_wait;
  logic                  wait_over;
  logic [3:0]            bit_count_inc;
  logic                  fail;
  logic [STATUS_W-1:0]   status;

  function automatic logic [TIMER_BITS-1:0] clip(input logic [CFG_W-1:0] v);
    logic [LW-1:0] ext;
    logic [LW-1:0] max_ext;
    ext     = LW'(v);
    max_ext = LW'(TIMER_MAX);
    return TIMER_BITS'((ext > max_ext) ? max_ext : ext);
  endfunction

  assign lim_inhibit   = clip(cfg.inhibit_ticks);
  assign lim_request   = clip(cfg.request_ticks);
  assign lim_wait      = clip(cfg.wait_limit);
  // saturating advance of the tick timer
  assign timer_sat     = (&tick_timer) ? tick_timer : tick_timer + 1'b1;
  assign wait_over     = tick_timer >= lim_wait;
  assign bit_count_inc = bit_count + 4'd1;

  always_comb begin
    phase_next        = phase;
    shift_byte_next   = shift_byte;
    parity_bit_next   = parity_bit;
    bit_count_next    = bit_count;
    tick_timer_next   = tick_timer;
    data_out_reg_next = data_out_reg;
    fail              = 1'b0;
    status            = ST_NONE;

    case (phase)
      PH_INHIBIT: begin
        tick_timer_next = timer_sat;
        if (timer_sat >= lim_inhibit) begin
          phase_next        = PH_REQUEST;
          tick_timer_next   = '0;
          data_out_reg_next = 1'b0;
        end
      end
      PH_REQUEST: begin
        tick_timer_next = timer_sat;
        if (timer_sat >= lim_request) begin
          phase_next      = PH_START;
          tick_timer_next = '0;
        end
      end
      PH_START: begin
        if (!clk_pin) begin
          bit_count_next    = 4'd0;
          data_out_reg_next = shift_byte[0];
          phase_next        = PH_BIT_HIGH;
          tick_timer_next   = '0;
        end else begin
          fail            = wait_over;
          tick_timer_next = tick_timer + 1'b1;
        end
      end
      PH_BIT_HIGH: begin
        if (clk_pin) begin
          phase_next      = PH_BIT_LOW;
          tick_timer_next = '0;
        end else begin
          fail            = wait_over;
          tick_timer_next = tick_timer + 1'b1;
        end
      end
      PH_BIT_LOW: begin
        if (!clk_pin) begin
          tick_timer_next = '0;
          if (bit_count >= 4'd8) begin
            phase_next        = PH_ACK_DLOW;
            data_out_reg_next = 1'b1;
          end else begin
            bit_count_next    = bit_count_inc;
            data_out_reg_next = (bit_count_inc >= 4'd8) ? parity_bit
                                                         : shift_byte[bit_count_inc[2:0]];
            phase_next        = PH_BIT_HIGH;
          end
        end else begin
          fail            = wait_over;
          tick_timer_next = tick_timer + 1'b1;
        end
      end
      PH_ACK_DLOW, PH_ACK_CLOW, PH_ACK_DHIGH, PH_ACK_CHIGH: begin
        logic met;
        case (phase)
          PH_ACK_DLOW:  met = !data_pin;
          PH_ACK_CLOW:  met = !clk_pin;
          PH_ACK_DHIGH: met = data_pin;
          default:      met = clk_pin;
        endcase
        if (met) begin
          tick_timer_next = '0;
          case (phase)
            PH_ACK_DLOW:  phase_next = PH_ACK_CLOW;
            PH_ACK_CLOW:  phase_next = PH_ACK_DHIGH;
            PH_ACK_DHIGH: phase_next = PH_ACK_CHIGH;
            default: begin
              phase_next = PH_IDLE;
              status     = ST_ACK;
            end
          endcase
        end else begin
          fail            = wait_over;
          tick_timer_next = tick_timer + 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (start_req) begin
          shift_byte_next   = command;
          parity_bit_next   = odd_parity(command);
          bit_count_next    = 4'd0;
          tick_timer_next   = '0;
          data_out_reg_next = 1'b1;
          phase_next        = PH_INHIBIT;
        end
      end
    endcase

    // timeout: release both lines and go idle
    if (fail) begin
      phase_next        = PH_IDLE;
      tick_timer_next   = '0;
      data_out_reg_next = 1'b1;
      status            = ST_TIMEOUT;
    end

    res.clk_pull_low = (phase_next == PH_INHIBIT) || (phase_next == PH_REQUEST);
    res.data_drive   = (phase_next >= PH_REQUEST) && (phase_next <= PH_BIT_LOW);
    res.data_level   = res.data_drive & data_out_reg_next;
    res.busy_res     = phase_next != PH_IDLE;
    res.status       = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      shift_byte   <= '0;
      parity_bit   <= 1'b0;
      bit_count    <= 4'd0;
      tick_timer   <= '0;
      data_out_reg <= 1'b1;
    end else if (fire) begin
      phase        <= phase_next;
      shift_byte   <= shift_byte_next;
      parity_bit   <= parity_bit_next;
      bit_count    <= bit_count_next;
      tick_timer   <= tick_timer_next;
      data_out_reg <= data_out_reg_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ps2hs_out_reg.sv =====
`default_nettype none

module ps2hs_out_reg
  import ps2hs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,
  input  wire res_t res_in,
  input  wire logic out_stall,
  output logic      out_valid,
  output res_t      res_out,
  output logic      hold
);

  // hold the input side only while a beat sits here and is not taken
  assign hold = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ps2_host_to_device_sender.sv =====
// PS/2 host-to-device command sender, one pin sample per input beat.
//
// Input channel (in_valid / in_stall): each beat is one tick carrying the
// sampled clk_pin and data_pin, plus start_req and command. A start is taken
// only while idle; the command byte is latched with it.
// Output channel (out_valid / out_stall): one result beat per input beat, in
// order: the line controls clk_pull_low, data_drive, data_level, busy_res
// and a one-beat status (acknowledged or timeout).
// Config port (cfg_we / cfg_index / cfg_wdata): inhibit_ticks, request_ticks
// and wait_limit; write only while idle.
//
// The result of a beat accepted at one edge is registered and is on the
// output after that edge. One beat is taken per cycle while the output is
// not stalled; the transfer sequencer's next-state logic sits between its
// state registers and the output register, so no beat waits on another.
// Reset clears the sequencer to idle, restores the register defaults
// (300, 20, 10000) and empties the output register; no beat is taken while
// rst is high. When the receiver stalls, the output beat holds and in_stall
// rises in the same cycle, so the sequencer advances only on accepted ticks.
`default_nettype none

module ps2_host_to_device_sender
  import ps2hs_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 start_req,
  input  wire logic [CMD_W-1:0]     command,
  input  wire logic                 clk_pin,
  input  wire logic                 data_pin,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      clk_pull_low,
  output logic                      data_drive,
  output logic                      data_level,
  output logic                      busy_res,
  output logic [STATUS_W-1:0]       status,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t cfg;
  res_t res_comb;
  res_t res_q;
  logic hold;
  logic fire;

  // take a beat whenever the output register is free or draining
  assign in_stall = rst || hold;
  assign fire     = in_valid && !in_stall;

  ps2hs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // transfer sequencer: advance one tick per accepted beat
  ps2hs_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .start_req (start_req),
    .command   (command),
    .clk_pin   (clk_pin),
    .data_pin  (data_pin),
    .cfg       (cfg),
    .res       (res_comb)
  );

  ps2hs_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_in    (res_comb),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (res_q),
    .hold      (hold)
  );

  assign clk_pull_low = res_q.clk_pull_low;
  assign data_drive   = res_q.data_drive;
  assign data_level   = res_q.data_level;
  assign busy_res     = res_q.busy_res;
  assign status       = res_q.status;

endmodule

`default_nettype wire

// ===== rtl/ps2hs_checker.sv =====
`default_nettype none

module ps2hs_checker
  import ps2hs_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic                clk_pull_low,
  input wire logic                data_drive,
  input wire logic                data_level,
  input wire logic                busy_res,
  input wire logic [STATUS_W-1:0] status
);

  // a stalled beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(busy_res)
      && $stable(data_level) && $stable(data_drive) && $stable(clk_pull_low))
    else $error("stalled result beat changed");

  // the input side stalls only behind a waiting result beat
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  // a finished transfer leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_NONE) |-> !busy_res && !clk_pull_low && !data_drive)
    else $error("status pulse while still busy");

  // released data line carries no level; clock inhibit only during a transfer
  a_lines: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (data_drive || !data_level) && (busy_res || !clk_pull_low))
    else $error("line controls inconsistent");

endmodule

bind ps2_host_to_device_sender ps2hs_checker u_ps2hs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .clk_pull_low (clk_pull_low),
  .data_drive   (data_drive),
  .data_level   (data_level),
  .busy_res     (busy_res),
  .status       (status)
);

`default_nettype wire
